// ===== hw/rtl/ckh_pkg.sv =====
// Shared types and constants of the cuckoo hash index.
`default_nettype none
package ckh_pkg;
   localparam int MAX_ITEMS  = 1024;
   localparam int ITEM_W     = $clog2(MAX_ITEMS);
   localparam int NUM_BINS   = 4096;
   localparam int BIN_W      = $clog2(NUM_BINS);
   localparam int STASH_SIZE = 8;
   localparam int SLOT_W     = $clog2(STASH_SIZE);
   localparam int SLOT_CW    = $clog2(STASH_SIZE + 1);
   localparam int LOC_W      = 13;
   localparam int KEY_W      = 64;
   localparam int CHOICE_W   = 2;
   localparam int STATUS_W   = 3;
   localparam int LIMIT_W    = 8;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DAT_W  = 8;
   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_HASHES     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REINSERT_LIMIT = 8'd1;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_PLACED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STASHED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic              is_find;
      logic [ITEM_W-1:0] item_index;
      logic [KEY_W-1:0]  key_low;
      logic [KEY_W-1:0]  key_high;
      logic [BIN_W-1:0]  bin_addr_2;
      logic [BIN_W-1:0]  bin_addr_1;
      logic [BIN_W-1:0]  bin_addr_0;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic [CHOICE_W-1:0] choice;
      logic [ITEM_W-1:0] item;
   } bin_entry_type;

   // front -> back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   // back -> front
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctrl_type;
endpackage
`default_nettype wire

// ===== hw/rtl/ckh_front.sv =====
// Request intake: decodes requests into a two-entry command queue.
`default_nettype none
module ckh_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [ckh_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                          req_tuser,
   input  wire ckh_pkg::back_ctrl_type        back_ctrl,
   output ckh_pkg::queue_out_type             queue_out
);
   import ckh_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    dec;

   always_comb begin
      dec.is_find    = (req_tuser == OP_FIND);
      dec.item_index = req_tdata[9:0];
      dec.key_low    = req_tdata[73:10];
      dec.key_high   = req_tdata[137:74];
      dec.bin_addr_0 = req_tdata[149:138];
      dec.bin_addr_1 = req_tdata[161:150];
      dec.bin_addr_2 = req_tdata[173:162];
   end

   assign req_tready      = (count_ff != 2'd2) && !back_ctrl.clearing;
   assign push            = req_tvalid && req_tready;
   assign queue_out.valid = (count_ff != 2'd0);
   assign queue_out.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = back_ctrl.pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, back_ctrl.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/ckh_back.sv =====
// Table engine: insert with cuckoo eviction and stash, find over bins and stash.
`default_nettype none
module ckh_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ckh_pkg::queue_out_type          queue_out,
   output ckh_pkg::back_ctrl_type               back_ctrl,
   input  wire logic [ckh_pkg::CHOICE_W-1:0]    num_hashes,
   input  wire logic [ckh_pkg::LIMIT_W-1:0]     reinsert_limit,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [ckh_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ckh_pkg::ITEM_W-1:0]           rsp_found_index,
   output logic [ckh_pkg::LOC_W-1:0]            rsp_location
);
   import ckh_pkg::*;

   typedef enum logic [11:0] {
      S_CLEAR   = 12'b0000_0000_0001,
      S_IDLE    = 12'b0000_0000_0010,
      S_INS_WR  = 12'b0000_0000_0100,
      S_P_CAND  = 12'b0000_0000_1000,
      S_P_CANDW = 12'b0000_0001_0000,
      S_P_BIN   = 12'b0000_0010_0000,
      S_F_BIN   = 12'b0000_0100_0000,
      S_F_CHK   = 12'b0000_1000_0000,
      S_F_KEY   = 12'b0001_0000_0000,
      S_S_ISSUE = 12'b0010_0000_0000,
      S_S_KEY   = 12'b0100_0000_0000,
      S_RESP    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // memories
   bin_entry_type          bin_mem  [NUM_BINS];
   logic [KEY_W-1:0]       klo_mem  [MAX_ITEMS];
   logic [KEY_W-1:0]       khi_mem  [MAX_ITEMS];
   logic [3*BIN_W-1:0]     cand_mem [MAX_ITEMS];
   bin_entry_type          bin_rd_ff;
   logic [KEY_W-1:0]       klo_rd_ff, khi_rd_ff;
   logic [3*BIN_W-1:0]     cand_rd_ff;

   logic                   bin_we;
   logic [BIN_W-1:0]       bin_wa, bin_ra;
   bin_entry_type          bin_wd;
   logic                   key_we;
   logic [ITEM_W-1:0]      key_ra, cand_ra;

   // stash in flops
   logic [STASH_SIZE-1:0]  stash_valid_ff, stash_valid_in;
   logic [ITEM_W-1:0]      stash_item_ff [STASH_SIZE];
   logic                   stash_we;
   logic [SLOT_W-1:0]      stash_wa;

   cmd_type                cmd_ff, cmd_in;
   logic [ITEM_W-1:0]      cur_item_ff, cur_item_in;
   logic [CHOICE_W-1:0]    choice_ff, choice_in;
   logic [LIMIT_W-1:0]     tries_ff, tries_in;
   logic [CHOICE_W-1:0]    hidx_ff, hidx_in;
   logic [SLOT_CW-1:0]     slot_ff, slot_in;
   logic [BIN_W-1:0]       addr_ff, addr_in;
   logic [BIN_W:0]         clr_ff, clr_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [ITEM_W-1:0]      fidx_ff, fidx_in;
   logic [LOC_W-1:0]       loc_ff, loc_in;

   logic [CHOICE_W-1:0]    nh;
   logic [CHOICE_W-1:0]    next_choice;
   logic [CHOICE_W:0]      choice_sum;
   logic [BIN_W-1:0]       cand_sel, find_addr;
   logic                   free_found;
   logic [SLOT_W-1:0]      free_slot;
   logic                   key_hit;
   logic                   slot_live;

   assign nh = (num_hashes == 2'd3) ? 2'd3 : 2'd2;
   assign key_hit = (klo_rd_ff == cmd_ff.key_low) && (khi_rd_ff == cmd_ff.key_high);
   assign slot_live = (slot_ff < SLOT_CW'(STASH_SIZE)) && stash_valid_ff[slot_ff[SLOT_W-1:0]];

   // next hash choice of the evicted entry, wrapped by the hash count
   always_comb begin
      choice_sum  = {1'b0, bin_rd_ff.choice} + 3'd1;
      next_choice = (choice_sum >= {1'b0, nh}) ? CHOICE_W'(choice_sum - {1'b0, nh})
                                              : choice_sum[CHOICE_W-1:0];
   end

   always_comb begin
      case (choice_ff)
         2'd1:    cand_sel = cand_rd_ff[2*BIN_W-1:BIN_W];
         2'd2:    cand_sel = cand_rd_ff[3*BIN_W-1:2*BIN_W];
         default: cand_sel = cand_rd_ff[BIN_W-1:0];
      endcase
      case (hidx_ff)
         2'd1:    find_addr = cmd_ff.bin_addr_1;
         2'd2:    find_addr = cmd_ff.bin_addr_2;
         default: find_addr = cmd_ff.bin_addr_0;
      endcase
   end

   // first free stash slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = STASH_SIZE - 1; s >= 0; s--) begin
         if (!stash_valid_ff[s]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      cur_item_in    = cur_item_ff;
      choice_in      = choice_ff;
      tries_in       = tries_ff;
      hidx_in        = hidx_ff;
      slot_in        = slot_ff;
      addr_in        = addr_ff;
      clr_in         = clr_ff;
      status_in      = status_ff;
      fidx_in        = fidx_ff;
      loc_in         = loc_ff;
      stash_valid_in = stash_valid_ff;
      bin_we         = 1'b0;
      bin_wa         = addr_ff;
      bin_wd         = '0;
      bin_ra         = find_addr;
      key_we         = 1'b0;
      key_ra         = cur_item_ff;
      cand_ra        = cur_item_ff;
      stash_we       = 1'b0;
      stash_wa       = free_slot;
      back_ctrl.pop  = 1'b0;
      back_ctrl.clearing = (state_ff == S_CLEAR);

      unique case (state_ff)
         S_CLEAR: begin
            bin_we = 1'b1;
            bin_wa = clr_ff[BIN_W-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (BIN_W+1)'(NUM_BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (queue_out.valid) begin
               back_ctrl.pop = 1'b1;
               cmd_in        = queue_out.cmd;
               hidx_in       = '0;
               fidx_in       = '0;
               loc_in        = '0;
               state_in      = queue_out.cmd.is_find ? S_F_BIN : S_INS_WR;
            end
         end
         S_INS_WR: begin
            key_we      = 1'b1;
            cur_item_in = cmd_ff.item_index;
            choice_in   = '0;
            tries_in    = '0;
            state_in    = S_P_CAND;
         end
         S_P_CAND: begin
            state_in = S_P_CANDW;
         end
         S_P_CANDW: begin
            bin_ra   = cand_sel;
            addr_in  = cand_sel;
            state_in = S_P_BIN;
         end
         S_P_BIN: begin
            bin_we = 1'b1;
            bin_wd = '{valid: 1'b1, choice: choice_ff, item: cur_item_ff};
            if (!bin_rd_ff.valid) begin
               status_in = ST_PLACED;
               state_in  = S_RESP;
            end else if (tries_ff != reinsert_limit) begin
               cur_item_in = bin_rd_ff.item;
               choice_in   = next_choice;
               tries_in    = tries_ff + 1'b1;
               state_in    = S_P_CAND;
            end else begin
               if (free_found) begin
                  stash_we                  = 1'b1;
                  stash_valid_in[free_slot] = 1'b1;
                  status_in                 = ST_STASHED;
               end else begin
                  status_in = ST_OVERFLOW;
               end
               state_in = S_RESP;
            end
         end
         S_F_BIN: begin
            addr_in  = find_addr;
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            if (bin_rd_ff.valid) begin
               key_ra      = bin_rd_ff.item;
               cur_item_in = bin_rd_ff.item;
               state_in    = S_F_KEY;
            end else if (hidx_ff + 2'd1 < nh) begin
               hidx_in  = hidx_ff + 2'd1;
               state_in = S_F_BIN;
            end else begin
               slot_in  = '0;
               state_in = S_S_ISSUE;
            end
         end
         S_F_KEY: begin
            if (key_hit) begin
               status_in = ST_FOUND;
               fidx_in   = cur_item_ff;
               loc_in    = LOC_W'(addr_ff);
               state_in  = S_RESP;
            end else if (hidx_ff + 2'd1 < nh) begin
               hidx_in  = hidx_ff + 2'd1;
               state_in = S_F_BIN;
            end else begin
               slot_in  = '0;
               state_in = S_S_ISSUE;
            end
         end
         S_S_ISSUE: begin
            if (slot_live) begin
               key_ra      = stash_item_ff[slot_ff[SLOT_W-1:0]];
               cur_item_in = stash_item_ff[slot_ff[SLOT_W-1:0]];
               state_in    = S_S_KEY;
            end else begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end
         end
         S_S_KEY: begin
            if (key_hit) begin
               status_in = ST_FOUND;
               fidx_in   = cur_item_ff;
               loc_in    = LOC_W'(NUM_BINS) + LOC_W'(slot_ff);
               state_in  = S_RESP;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = S_S_ISSUE;
            end
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid      = (state_ff == S_RESP);
   assign rsp_status      = status_ff;
   assign rsp_found_index = fidx_ff;
   assign rsp_location    = loc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         stash_valid_ff <= '0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         stash_valid_ff <= stash_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cur_item_ff <= cur_item_in;
      choice_ff   <= choice_in;
      tries_ff    <= tries_in;
      hidx_ff     <= hidx_in;
      slot_ff     <= slot_in;
      addr_ff     <= addr_in;
      status_ff   <= status_in;
      fidx_ff     <= fidx_in;
      loc_ff      <= loc_in;
      if (stash_we) begin
         stash_item_ff[stash_wa] <= bin_rd_ff.item;
      end
   end

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_wa] <= bin_wd;
      end
      bin_rd_ff <= bin_mem[bin_ra];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         klo_mem[cmd_ff.item_index]  <= cmd_ff.key_low;
         khi_mem[cmd_ff.item_index]  <= cmd_ff.key_high;
         cand_mem[cmd_ff.item_index] <= {cmd_ff.bin_addr_2, cmd_ff.bin_addr_1,
                                         cmd_ff.bin_addr_0};
      end
      klo_rd_ff  <= klo_mem[key_ra];
      khi_rd_ff  <= khi_mem[key_ra];
      cand_rd_ff <= cand_mem[cand_ra];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/cuckoo_hash_index_with_stash.sv =====
// Top level of the cuckoo hash index with stash.
// Usage:
//  - req_ channel: one request is an insert (req_tuser 0) or a find (req_tuser 1).
//    Inserts store key and candidate bins under item_index, then place the item
//    by cuckoo eviction; after reinsert_limit kicks the evicted item goes to the
//    first free stash slot, or is dropped with overflow status.
//  - rsp_ channel: one response per request; rsp_tuser carries the status.
//  - csr_ channel: index 0 num_hashes (2 or 3), index 1 reinsert_limit; always
//    ready, write only while idle.
// Operation: a find checks each candidate bin in turn, reading the key store for an
// occupied bin, then walks the stash slots; an insert repeats a placement step
// (candidate read, bin read, bin write) for the item and each evicted item. All table
// accesses go through memories with one read and one write port; one request is worked at a time.
// Reset: the bin table is swept clear, one bin per cycle, all 4096 bins;
// req_tready stays low until the sweep ends. Stash valid bits clear at once.
// Stall: a response waits in its register while rsp_tready is low; the front
// queue still takes up to two more requests meanwhile.
`default_nettype none
module cuckoo_hash_index_with_stash (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // item_index, key_low, key_high, bin_addr_0, bin_addr_1, bin_addr_2, pad
   input  wire logic [ckh_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // found_index, location, pad
   output logic [ckh_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // status
   output logic [ckh_pkg::STATUS_W-1:0]          rsp_tuser,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ckh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ckh_pkg::CSR_DAT_W-1:0]    csr_data
);
   import ckh_pkg::*;

   queue_out_type        queue_out;
   back_ctrl_type        back_ctrl;
   logic [CHOICE_W-1:0]  num_hashes_ff;
   logic [LIMIT_W-1:0]   reinsert_limit_ff;
   logic [ITEM_W-1:0]    found_index;
   logic [LOC_W-1:0]     location;

   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_hashes_ff     <= 2'd3;
         reinsert_limit_ff <= 8'd100;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_HASHES:     num_hashes_ff     <= csr_data[CHOICE_W-1:0];
            CSR_REINSERT_LIMIT: reinsert_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ckh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .back_ctrl  (back_ctrl),
      .queue_out  (queue_out)
   );

   ckh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_out       (queue_out),
      .back_ctrl       (back_ctrl),
      .num_hashes      (num_hashes_ff),
      .reinsert_limit  (reinsert_limit_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_tuser),
      .rsp_found_index (found_index),
      .rsp_location    (location)
   );

   assign rsp_tdata = {1'b0, location, found_index};
endmodule
`default_nettype wire

// ===== hw/rtl/ckh_checker.sv =====
// Port-level checks of the cuckoo hash index, bound to the top level.
`default_nettype none
module ckh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser
);
   import ckh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_NOT_FOUND)
      else $error("status code out of range");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_FOUND |-> rsp_tdata == '0)
      else $error("non-found response carries data");

   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during table clear");
endmodule

bind cuckoo_hash_index_with_stash ckh_checker u_ckh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== bench/tb_cuckoo_hash_index_with_stash.sv =====
// Self-checking bench for the cuckoo hash index: mirrors bins and stash, checks every response.
`default_nettype none

import ckh_pkg::*;

typedef struct {
   logic              is_find;
   logic [ITEM_W-1:0] idx;
   logic [KEY_W-1:0]  lo;
   logic [KEY_W-1:0]  hi;
   logic [BIN_W-1:0]  a0;
   logic [BIN_W-1:0]  a1;
   logic [BIN_W-1:0]  a2;
} hash_request_t;

typedef struct {
   logic [STATUS_W-1:0] status;
   logic [ITEM_W-1:0]   found_idx;
   logic [LOC_W-1:0]    loc;
} hash_reply_t;

// Mirror of the bin table, stash and key stores; computes each reply as requests are accepted.
class stash_index_mirror;
   bit                bin_v  [NUM_BINS];
   bit [CHOICE_W-1:0] bin_ch [NUM_BINS];
   bit [ITEM_W-1:0]   bin_it [NUM_BINS];
   bit                st_v   [STASH_SIZE];
   bit [CHOICE_W-1:0] st_ch  [STASH_SIZE];
   bit [ITEM_W-1:0]   st_it  [STASH_SIZE];
   bit [KEY_W-1:0]    key_lo [MAX_ITEMS];
   bit [KEY_W-1:0]    key_hi [MAX_ITEMS];
   bit [BIN_W-1:0]    cand   [MAX_ITEMS][3];
   int                num_hashes = 3;
   int                kick_limit = 100;
   hash_reply_t       pending_replies[$];
   int                mismatches = 0;

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      if (idx == CSR_NUM_HASHES) num_hashes = val & 3;
      else if (idx == CSR_REINSERT_LIMIT) kick_limit = val;
   endfunction

   // 0 and 1 act as two choices
   function int choices();
      return (num_hashes >= 3) ? 3 : 2;
   endfunction

   function logic [STATUS_W-1:0] place(bit [ITEM_W-1:0] it);
      int                tries;
      bit [CHOICE_W-1:0] ch;
      bit [BIN_W-1:0]    ad;
      bit                old_v;
      bit [CHOICE_W-1:0] old_ch;
      bit [ITEM_W-1:0]   old_it;
      tries = 0;
      ch = 0;
      while (1) begin
         ad = cand[it][ch % 3];
         old_v = bin_v[ad]; old_ch = bin_ch[ad]; old_it = bin_it[ad];
         bin_v[ad] = 1; bin_ch[ad] = ch; bin_it[ad] = it;
         if (!old_v) return ST_PLACED;
         it = old_it;
         ch = old_ch;
         if (tries != kick_limit) begin
            ch = CHOICE_W'((int'(ch) + 1) % choices());
            tries++;
         end else begin
            // chain exhausted: evicted item goes to first free stash slot or is lost
            for (int s = 0; s < STASH_SIZE; s++) begin
               if (!st_v[s]) begin
                  st_v[s] = 1; st_ch[s] = ch; st_it[s] = it;
                  return ST_STASHED;
               end
            end
            return ST_OVERFLOW;
         end
      end
   endfunction

   function void note_request(hash_request_t r);
      hash_reply_t       rep;
      bit [BIN_W-1:0]    ads[3];
      rep = '{ST_NOT_FOUND, '0, '0};
      ads = '{r.a0, r.a1, r.a2};
      if (r.is_find == OP_INSERT) begin
         key_lo[r.idx] = r.lo;
         key_hi[r.idx] = r.hi;
         for (int i = 0; i < 3; i++) cand[r.idx][i] = ads[i];
         rep.status = place(r.idx);
      end else begin
         for (int i = 0; i < choices() && rep.status != ST_FOUND; i++) begin
            if (bin_v[ads[i]] && key_lo[bin_it[ads[i]]] == r.lo
                && key_hi[bin_it[ads[i]]] == r.hi) begin
               rep = '{ST_FOUND, bin_it[ads[i]], LOC_W'(ads[i])};
            end
         end
         for (int s = 0; s < STASH_SIZE && rep.status != ST_FOUND && st_v[s]; s++) begin
            if (key_lo[st_it[s]] == r.lo && key_hi[st_it[s]] == r.hi)
               rep = '{ST_FOUND, st_it[s], LOC_W'(NUM_BINS + s)};
         end
      end
      pending_replies.push_back(rep);
   endfunction

   function void check_response(hash_reply_t got);
      hash_reply_t want;
      if (pending_replies.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response status=%0d idx=%0d loc=%0d",
                     got.status, got.found_idx, got.loc);
         return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.found_idx !== want.found_idx
          || got.loc !== want.loc) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response mismatch: exp status=%0d idx=%0d loc=%0d,",
                     want.status, want.found_idx, want.loc,
                     " got status=%0d idx=%0d loc=%0d",
                     got.status, got.found_idx, got.loc);
      end
   endfunction
endclass

module tb_cuckoo_hash_index_with_stash;
   timeunit 1ns;
   timeprecision 1ps;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DAT_W-1:0]    csr_data = '0;

   stash_index_mirror mirror = new();

   // no-idle stretch: both sides run flat out while set
   bit                no_idle = 1'b0;
   // keys last inserted per index, so finds can hit
   bit                used_idx [MAX_ITEMS];
   hash_request_t     last_insert [MAX_ITEMS];
   int                bin_span = 16;

   cuckoo_hash_index_with_stash DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side: random backpressure, check on every handshake
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_response('{rsp_tuser, rsp_tdata[ITEM_W-1:0],
                                 rsp_tdata[ITEM_W +: LOC_W]});
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 26);
   end

   // generous cap: worst case is every insert running 255 kicks under stall
   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   // one request on the req channel; leaves tvalid high only when the next
   // caller raises it again in the same step (no idle drop in between)
   task automatic send_request(hash_request_t r);
      while (!no_idle && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.is_find;
      // pad, a2, a1, a0, key_high, key_low, item_index (high bits first)
      req_tdata  <= {2'b00, r.a2, r.a1, r.a0, r.hi, r.lo, r.idx};
      do @(posedge clock); while (!req_tready);
      mirror.note_request(r);
      if (r.is_find == OP_INSERT) begin
         used_idx[r.idx] = 1'b1;
         last_insert[r.idx] = r;
      end
   endtask

   // drain: wait for every reply, then a margin for a chain still running
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (mirror.pending_replies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      mirror.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic hash_request_t mk(logic f, logic [ITEM_W-1:0] i, logic [KEY_W-1:0] l,
                                        logic [KEY_W-1:0] h, logic [BIN_W-1:0] b0,
                                        logic [BIN_W-1:0] b1, logic [BIN_W-1:0] b2);
      hash_request_t r;
      r = '{f, i, l, h, b0, b1, b2};
      return r;
   endfunction

   function automatic logic [BIN_W-1:0] pick_bin();
      // mostly a narrow window to force collisions, sometimes the whole range
      if ($urandom_range(0, 9) == 0) return BIN_W'($urandom);
      return BIN_W'($urandom_range(0, bin_span - 1));
   endfunction

   function automatic hash_request_t random_request();
      hash_request_t r;
      int            k;
      r = mk(OP_INSERT, ITEM_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
             pick_bin(), pick_bin(), pick_bin());
      if ($urandom_range(0, 99) < 45) begin
         r.is_find = OP_FIND;
         if ($urandom_range(0, 3) != 0) begin
            // find a key that was inserted, with its own candidates
            k = $urandom_range(0, MAX_ITEMS - 1);
            for (int n = 0; n < MAX_ITEMS && !used_idx[k]; n++) k = (k + 1) % MAX_ITEMS;
            if (used_idx[k]) begin
               r = last_insert[k];
               r.is_find = OP_FIND;
               r.idx = ITEM_W'($urandom);
               // sometimes rotate candidates so the hit moves to another probe
               if ($urandom_range(0, 3) == 0) r = mk(OP_FIND, r.idx, r.lo, r.hi, r.a2, r.a0, r.a1);
            end
         end
      end
      return r;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_request(random_request());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, both ops, repeated insert, stash fill and overflow
      send_request(mk(OP_INSERT, '0, '0, '0, '0, '0, '0));
      send_request(mk(OP_INSERT, '1, '1, '1, '1, '1, '1));
      send_request(mk(OP_FIND,   '0, '0, '0, '0, '1, '1));
      send_request(mk(OP_FIND,   '0, '1, '1, '1, '0, '0));
      send_request(mk(OP_FIND,   '0, 64'h5, 64'h7, '0, '1, 12'd9));
      // chain in bin 0: evicts item 0 to its other choices
      send_request(mk(OP_INSERT, 10'd7, 64'hA, 64'hB, 12'd0, 12'd1, 12'd2));
      send_request(mk(OP_FIND,   '0, '0, '0, 12'd1, 12'd0, 12'd0));
      // same index again with new key and bins, old entry stays behind
      send_request(mk(OP_INSERT, 10'd7, 64'hC, 64'hD, 12'd3, 12'd4, 12'd5));
      send_request(mk(OP_FIND,   '0, 64'hA, 64'hB, 12'd0, 12'd1, 12'd2));
      send_request(mk(OP_FIND,   '0, 64'hC, 64'hD, 12'd3, 12'd4, 12'd5));
      drain();

      // no kicks, two choices: every collision goes straight to the stash
      write_csr(CSR_NUM_HASHES, 8'd2);
      write_csr(CSR_REINSERT_LIMIT, 8'd0);
      for (int i = 0; i < 11; i++)
         send_request(mk(OP_INSERT, 10'(100 + i), 64'(i + 1), 64'hF0, 12'd20, 12'd21, 12'd22));
      send_request(mk(OP_FIND, '0, 64'd1, 64'hF0, 12'd20, 12'd21, 12'd22));
      send_request(mk(OP_FIND, '0, 64'd11, 64'hF0, 12'd20, 12'd21, 12'd22));
      drain();

      // random phases across register settings, extremes included
      write_csr(CSR_NUM_HASHES, 8'd3);
      write_csr(CSR_REINSERT_LIMIT, 8'd255);
      bin_span = 256;
      random_phase(150);
      // pause until every reply is back before carrying on
      drain();
      random_phase(50);
      drain();

      write_csr(CSR_NUM_HASHES, 8'd0);
      write_csr(CSR_REINSERT_LIMIT, 8'd3);
      bin_span = 16;
      no_idle = 1'b1;
      random_phase(150);
      no_idle = 1'b0;
      drain();

      write_csr(CSR_NUM_HASHES, 8'd1);
      write_csr(CSR_REINSERT_LIMIT, 8'd1);
      bin_span = 64;
      random_phase(150);
      drain();

      write_csr(CSR_NUM_HASHES, 8'd3);
      write_csr(CSR_REINSERT_LIMIT, 8'd100);
      bin_span = 4096;
      random_phase(300);
      drain();

      if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

`default_nettype wire
